// ===== src/spg_pkg.sv =====
// shared constants and widths for the stepper pulse train generator
`default_nettype none
package spg_pkg;

    localparam int MAX_EDGES   = 4;
    localparam int ClkHzW      = 30;
    localparam int NowW        = 32;
    localparam int RateW       = 16;
    localparam int DivisorW    = RateW + 1;
    localparam int HalfW       = 32;
    localparam int EdgesOutW   = 3;
    localparam int EdgeCntRawW = $clog2(MAX_EDGES + 1);
    localparam int EdgeCntW    = (EdgeCntRawW > EdgesOutW) ? EdgeCntRawW : EdgesOutW;
    localparam int DivCntW     = $clog2(ClkHzW);
    localparam int InDataW     = 56;
    localparam int OutDataW    = 8;
    localparam int CfgAddrW    = 2;
    localparam int CfgDataW    = 32;

    localparam logic [ClkHzW-1:0] ClkHzReset = ClkHzW'(600000000);

endpackage
`default_nettype wire

// ===== src/stepper_pulse_train_generator.sv =====
// stepper step/dir pulse train generator top level with service-call sequencer
// a running call passes S_PREP and S_EDGE before its result is registered in S_DONE, and the next
// item is accepted once back in S_IDLE (edges up to MAX_EDGES, one toggle per cycle)
// a changed nonzero rate first waits in S_DIV for the serial half-period divider
// a stop or disabled call goes straight from S_IDLE to S_DONE; results wait in an output register
// one item is worked on at a time: s_tready is high only while the sequencer idles
// reset (synchronous, active low) restores clock_hz to 600000000 and pin state to dir=step=1
`default_nettype none
module stepper_pulse_train_generator
    import spg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] now_cycles, [47:32] step_rate, [48] drive_enable, [55:49] zero
    input  wire logic [InDataW-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [0] dir_level, [1] step_level, [2] enable_level, [5:3] edges_made, [7:6] zero
    output logic      [OutDataW-1:0] m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [CfgDataW-1:0] pwdata,
    output logic      [CfgDataW-1:0] prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_EDGE,
        S_DONE
    } t_state;

    t_state r_state;

    logic [ClkHzW-1:0]   w_clock_hz;
    logic                w_div_done;
    logic [ClkHzW-1:0]   w_quotient;
    logic                w_div_start;

    logic                r_dir_is_high;
    logic                r_dir_pin;
    logic                r_step_pin;
    logic [NowW-1:0]     r_deadline;
    logic [HalfW-1:0]    r_half;
    logic [RateW-1:0]    r_last_rate;
    logic                r_stop_pending;

    logic [NowW-1:0]     r_now;
    logic                r_en;
    logic [NowW-1:0]     r_diff;
    logic [EdgeCntW-1:0] r_edges;
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out;

    logic                w_accept;
    logic [NowW-1:0]     w_in_now;
    logic [RateW-1:0]    w_in_rate;
    logic                w_in_en;
    logic                w_run;
    logic                w_new_rate;
    logic                w_want_high;
    logic [DivisorW-1:0] w_mag;
    logic [DivisorW-1:0] w_divisor;
    logic                w_edge_due;
    logic [OutDataW-1:0] n_out;

    spg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_clock_hz (w_clock_hz)
    );

    spg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_clock_hz),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign s_tready  = (r_state == S_IDLE);
    assign w_accept  = s_tvalid & s_tready;
    assign w_in_now  = s_tdata[NowW-1:0];
    assign w_in_rate = s_tdata[NowW+RateW-1:NowW];
    assign w_in_en   = s_tdata[NowW+RateW];

    assign w_run       = (w_in_rate != '0) & w_in_en;
    assign w_new_rate  = (w_in_rate != r_last_rate);
    assign w_want_high = w_in_rate[RateW-1];
    assign w_mag       = w_want_high ? DivisorW'(~{1'b1, w_in_rate} + 1'b1)
                                     : {1'b0, w_in_rate};
    // divisor is twice the magnitude
    assign w_divisor   = {w_mag[DivisorW-2:0], 1'b0};
    assign w_div_start = w_accept & w_run & w_new_rate;

    // wrapping signed compare of elapsed time against the half period
    assign w_edge_due = (r_edges < EdgeCntW'(MAX_EDGES)) &&
                        ($signed(r_diff) >= $signed(r_half));

    assign n_out = {{(OutDataW-6){1'b0}}, r_edges[EdgesOutW-1:0], r_en, r_step_pin,
                    r_dir_pin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_dir_is_high  <= 1'b1;
            r_dir_pin      <= 1'b1;
            r_step_pin     <= 1'b1;
            r_deadline     <= '0;
            r_half         <= '0;
            r_last_rate    <= '0;
            r_stop_pending <= 1'b0;
            r_edges        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // in S_DONE the output register is refilled or held instead
            if (r_state != S_DONE && r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_now   <= w_in_now;
                        r_en    <= w_in_en;
                        r_edges <= '0;
                        if (w_run) begin
                            r_stop_pending <= 1'b1;
                            if (w_new_rate) begin
                                if (w_want_high != r_dir_is_high) begin
                                    r_step_pin    <= 1'b0;
                                    r_dir_is_high <= w_want_high;
                                    r_dir_pin     <= w_want_high;
                                    r_deadline    <= w_in_now;
                                end else if (r_last_rate == '0) begin
                                    r_dir_pin  <= r_dir_is_high;
                                    r_deadline <= w_in_now;
                                end
                                r_last_rate <= w_in_rate;
                                r_state     <= S_DIV;
                            end else begin
                                r_state <= S_PREP;
                            end
                        end else begin
                            if (r_stop_pending) begin
                                r_stop_pending <= 1'b0;
                                r_last_rate    <= '0;
                                r_half         <= '0;
                                r_step_pin     <= 1'b0;
                                r_dir_pin      <= 1'b0;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        // clamp a zero quotient to 1
                        if (w_quotient == '0) begin
                            r_half <= HalfW'(1);
                        end else begin
                            r_half <= HalfW'(w_quotient);
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_diff  <= r_now - r_deadline;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (w_edge_due) begin
                        r_deadline <= r_deadline + r_half;
                        r_diff     <= r_diff - r_half;
                        r_step_pin <= ~r_step_pin;
                        r_edges    <= r_edges + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_tready) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

endmodule
`default_nettype wire

// ===== src/spg_cfg_regs.sv =====
// apb register holding the timestamp counter rate
`default_nettype none
module spg_cfg_regs
    import spg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [CfgDataW-1:0] pwdata,
    output logic      [CfgDataW-1:0] prdata,
    output logic                     pready,
    output logic      [ClkHzW-1:0]   o_clock_hz
);

    logic [ClkHzW-1:0] r_clock_hz;
    logic              w_wr;

    // single register: every address within the port decodes to it
    assign w_wr = psel & penable & pwrite & (paddr == paddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ClkHzReset;
        end else if (w_wr) begin
            r_clock_hz <= pwdata[ClkHzW-1:0];
        end
    end

    assign prdata     = {{(CfgDataW-ClkHzW){1'b0}}, r_clock_hz};
    assign pready     = 1'b1;
    assign o_clock_hz = r_clock_hz;

endmodule
`default_nettype wire

// ===== src/spg_divider.sv =====
// bit-serial restoring divider for the half period
`default_nettype none
module spg_divider
    import spg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [ClkHzW-1:0]   i_dividend,
    input  wire logic [DivisorW-1:0] i_divisor,
    output logic                     o_done,
    output logic      [ClkHzW-1:0]   o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [DivCntW-1:0]  r_count;
    logic [DivisorW-1:0] r_rem;
    logic [DivisorW-1:0] r_div;
    logic [ClkHzW-1:0]   r_quo;
    logic [DivisorW:0]   w_trial;
    logic                w_fit;

    // shift in the next dividend bit and try one subtraction
    assign w_trial = {r_rem, r_quo[ClkHzW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
                r_rem   <= '0;
                r_div   <= i_divisor;
                r_quo   <= i_dividend;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= DivisorW'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[DivisorW-1:0];
                end
                r_quo <= {r_quo[ClkHzW-2:0], w_fit};
                if (r_count == DivCntW'(ClkHzW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== src/spg_checker.sv =====
// port-level checker for the pulse train generator and its bind
`default_nettype none
module spg_checker
    import spg_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OutDataW-1:0] m_tdata,
    input wire logic                pready
);

    localparam int EdgeCap = (MAX_EDGES > 7) ? 7 : MAX_EDGES;

    // one item at a time: no second item right after an accepted one
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_edge_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[5:3] <= 3'(EdgeCap)))
        else $error("edge count above limit");

    // a disabled call reports no edges
    a_disabled_no_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[5:3] == 3'd0 && !m_tdata[1]
                                       && !m_tdata[0]) || (m_tdata[5:3] == 3'd0))
        else $error("edges reported on a disabled call");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind stepper_pulse_train_generator spg_checker u_spg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire

// ===== dv/spg_pin_scoreboard.sv =====
// scoreboard for the stepper pulse generator: predicts pin levels per service call and checks them
`default_nettype none
module spg_pin_scoreboard
    import spg_pkg::*;
#(
    parameter logic [CfgAddrW-1:0] ClkHzAddr = '0
)
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    // [31:0] now_cycles, [47:32] step_rate, [48] drive_enable, [55:49] zero
    input  wire logic [InDataW-1:0]  s_tdata,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    // [0] dir_level, [1] step_level, [2] enable_level, [5:3] edges_made, [7:6] zero
    input  wire logic [OutDataW-1:0] m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [CfgDataW-1:0] pwdata,
    input  wire logic                pready,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic                 dir;
        logic                 step;
        logic                 en;
        logic [EdgesOutW-1:0] edges;
    } pin_levels_t;

    pin_levels_t pending_pins[$];
    int          mismatches = 0;

    // mirror of the generator state
    logic [ClkHzW-1:0]       clock_hz;
    logic                    dir_high;
    logic                    dir_pin;
    logic                    step_pin;
    logic [NowW-1:0]         deadline;
    logic [HalfW-1:0]        half_period;
    logic signed [RateW-1:0] prev_rate;
    logic                    stop_armed;

    assign o_fail_count = mismatches;

    function automatic pin_levels_t compute_pins(logic [NowW-1:0] now,
                                                 logic signed [RateW-1:0] rate,
                                                 logic en);
        pin_levels_t     lv;
        int unsigned     edges;
        logic [RateW:0]  mag;
        logic [63:0]     quot;
        edges = 0;
        if (rate != 0 && en) begin
            stop_armed = 1'b1;
            if (rate != prev_rate) begin
                if ((rate < 0) != dir_high) begin
                    // direction flip: step low, phase re-based on this call
                    step_pin = 1'b0;
                    dir_high = (rate < 0);
                    dir_pin  = dir_high;
                    deadline = now;
                end else if (prev_rate == 0) begin
                    dir_pin  = dir_high;
                    deadline = now;
                end
                mag  = (rate < 0) ? (RateW+1)'(-int'(rate)) : (RateW+1)'(int'(rate));
                quot = 64'(clock_hz) / (64'(mag) << 1);
                if (quot == 0) begin
                    quot = 1;
                end
                half_period = quot[HalfW-1:0];
                prev_rate   = rate;
            end
            while (edges < MAX_EDGES && $signed(now - deadline) >= $signed(half_period)) begin
                deadline += half_period;
                step_pin  = ~step_pin;
                edges++;
            end
        end else if (stop_armed) begin
            stop_armed  = 1'b0;
            prev_rate   = '0;
            half_period = '0;
            step_pin    = 1'b0;
            dir_pin     = 1'b0;
        end
        lv.dir   = dir_pin;
        lv.step  = step_pin;
        lv.en    = en;
        lv.edges = edges[EdgesOutW-1:0];
        return lv;
    endfunction

    function automatic void note_mismatch(string what, int exp_v, int act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        pin_levels_t want;
        if (!i_rst_n) begin
            clock_hz    = ClkHzReset;
            dir_high    = 1'b1;
            dir_pin     = 1'b1;
            step_pin    = 1'b1;
            deadline    = '0;
            half_period = '0;
            prev_rate   = '0;
            stop_armed  = 1'b0;
            pending_pins.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ClkHzAddr) begin
                clock_hz = pwdata[ClkHzW-1:0];
            end
            // check the output side first so an item cannot match its own result
            if (m_tvalid && m_tready) begin
                if (pending_pins.size() == 0) begin
                    note_mismatch("unexpected result item, data", 0, int'(m_tdata));
                end else begin
                    want = pending_pins.pop_front();
                    if (m_tdata[0] !== want.dir) begin
                        note_mismatch("dir_level", want.dir, m_tdata[0]);
                    end
                    if (m_tdata[1] !== want.step) begin
                        note_mismatch("step_level", want.step, m_tdata[1]);
                    end
                    if (m_tdata[2] !== want.en) begin
                        note_mismatch("enable_level", want.en, m_tdata[2]);
                    end
                    if (m_tdata[5:3] !== want.edges) begin
                        note_mismatch("edges_made", want.edges, m_tdata[5:3]);
                    end
                    if (m_tdata[OutDataW-1:6] !== '0) begin
                        note_mismatch("tdata padding", 0, m_tdata[OutDataW-1:6]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_pins.push_back(compute_pins(s_tdata[31:0], s_tdata[47:32], s_tdata[48]));
            end
        end
        o_pending = pending_pins.size();
    end

endmodule
`default_nettype wire

// ===== dv/stepper_pulse_train_generator_test.sv =====
// testbench top for the stepper pulse generator: clock, reset, stimulus and verdict
`default_nettype none
module stepper_pulse_train_generator_test;
    import spg_pkg::*;

    localparam logic [CfgAddrW-1:0] ClkHzAddr      = CfgAddrW'(0);
    localparam int unsigned         CycleLimit     = 1_000_000;
    localparam int                  RandomPerPhase = 205;
    localparam int                  LongHold       = 300;
    localparam int                  NumSettings    = 7;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CfgAddrW-1:0] paddr    = '0;
    logic [CfgDataW-1:0] pwdata   = '0;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    int fail_count;
    int pending;

    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count   = 0;
    int          calls_sent    = 0;
    int          stops_sent    = 0;
    int          rate_changes  = 0;
    longint      hz            = 600_000_000;

    logic [NowW-1:0]         now_ts;
    logic signed [RateW-1:0] rate_cmd;

    int unsigned clock_settings[NumSettings] = '{1_000_000_000, 0, 1, 50_000,
                                                 3_000_000, 600_000_000, 123_456_789};

    stepper_pulse_train_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spg_pin_scoreboard #(.ClkHzAddr(ClkHzAddr)) pin_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                gap = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic send_call(input logic [NowW-1:0] now, input logic signed [RateW-1:0] rate,
                             input logic en);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, en, rate, now};
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        calls_sent++;
        if (rate == 0 || !en) begin
            stops_sent++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_clock_hz(input logic [CfgDataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ClkHzAddr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [RateW-1:0] pick_rate(logic signed [RateW-1:0] cur);
        int m;
        case ($urandom_range(0, 4))
            0: begin
                case ($urandom_range(0, 3))
                    0:       m = 32767;
                    1:       m = -32768;
                    2:       m = 1;
                    default: m = -1;
                endcase
            end
            1:       m = $urandom_range(1, 200);
            2:       m = $urandom_range(1, 5000);
            3:       m = $urandom;
            default: m = -int'(cur);
        endcase
        if ($urandom_range(0, 1) == 1) begin
            m = -m;
        end
        return RateW'(m);
    endfunction

    // next timestamp, mostly a few half periods on so the edge count varies
    task automatic advance_now();
        longint mag;
        longint hp;
        longint delta;
        mag = (rate_cmd < 0) ? -longint'(rate_cmd) : longint'(rate_cmd);
        hp  = (mag == 0) ? 1000 : hz / (2 * mag);
        if (hp == 0) begin
            hp = 1;
        end
        delta = hp * $urandom_range(0, 14) / 4 + $urandom_range(0, 3);
        if ($urandom_range(0, 49) == 0) begin
            now_ts = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        end else begin
            now_ts = now_ts + delta[NowW-1:0];
        end
    endtask

    initial begin
        logic                    en;
        logic signed [RateW-1:0] send_rate;
        int                      sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed calls at the reset clock rate (half period 300000 at 1000 steps/s)
        send_call(32'd0,       0,     1'b1);   // stop with nothing running
        send_call(32'd5,       1000,  1'b0);   // disabled while idle
        send_call(32'd100,     1000,  1'b1);   // first start flips dir low
        send_call(32'd300100,  1000,  1'b1);
        send_call(32'd2100100, 1000,  1'b1);   // backlog capped at max edges
        send_call(32'd2100100, 1000,  1'b1);
        send_call(32'd2200000, -1000, 1'b1);   // flip to dir high
        send_call(32'd2500000, -2000, 1'b1);   // same dir, new rate
        send_call(32'd2600000, 0,     1'b1);   // stop one-shot
        send_call(32'd2700000, 0,     1'b1);
        send_call(32'd2800000, -2000, 1'b1);   // restart from stop
        send_call(32'd3000000, -2000, 1'b0);   // disable stops too
        send_call(32'd3100000, 32767, 1'b1);
        send_call(32'd3200000, 32767, 1'b1);
        send_call(32'd3300000, -32768, 1'b1);
        send_call(32'd3400000, 1,     1'b1);
        send_call(32'hFFFF_FF00, 1,   1'b1);
        send_call(32'h0000_0100, -1,  1'b1);
        send_call(32'hFFFF_FFFF, -1,  1'b1);
        send_call(32'h7FFF_FFFF, -1,  1'b1);   // signed compare around half range
        send_call(32'h8000_0000, -1,  1'b1);
        send_call(32'h1234_5678, 16'sh5A5A, 1'b0);
        s_tvalid <= 1'b0;

        now_ts   = 32'd0;
        rate_cmd = 16'sd1000;
        for (int ph = 0; ph < NumSettings; ph++) begin
            wait_drained();
            write_clock_hz(clock_settings[ph]);
            hz      = clock_settings[ph];
            idle_on = (ph != NumSettings - 1);
            if (ph == 0) begin
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < RandomPerPhase; i++) begin
                sel       = $urandom_range(0, 99);
                en        = 1'b1;
                send_rate = rate_cmd;
                if (sel < 6) begin
                    now_ts    = $urandom;
                    send_rate = RateW'($urandom);
                    en        = 1'($urandom_range(0, 1));
                end else begin
                    if (sel < 11) begin
                        send_rate = '0;
                    end else if (sel < 14) begin
                        en = 1'b0;
                    end else if (sel < 26) begin
                        rate_cmd  = pick_rate(rate_cmd);
                        send_rate = rate_cmd;
                        rate_changes++;
                    end
                    advance_now();
                end
                send_call(now_ts, send_rate, en);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d service calls over %0d clock rates plus the reset rate",
                 calls_sent, NumSettings);
        $display("  %0d rate changes, %0d stop or disable calls, one long output hold-off",
                 rate_changes, stops_sent);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
